// ===== hdl/arpc_pkg.sv =====
// Package for the ARP cache with request retry.
// Holds table sizes, field widths, codes and the structs shared between the modules.
// No dependencies.
package arpc_pkg;

	// Table sizes.
	localparam int ENTRY_DEPTH   = 16;
	localparam int REQ_DEPTH     = 8;
	localparam int PENDING_DEPTH = 4;

	// Index and count widths derived from the sizes.
	localparam int EIDX_W = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
	localparam int ECNT_W = $clog2(ENTRY_DEPTH + 1);
	localparam int RIDX_W = (REQ_DEPTH > 1) ? $clog2(REQ_DEPTH) : 1;
	localparam int RCNT_W = $clog2(REQ_DEPTH + 1);
	localparam int PIDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int PCNT_W = $clog2(PENDING_DEPTH + 1);

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SENDS = 1'd1;
	localparam logic [15:0] TIMEOUT_RESET   = 16'd30;
	localparam logic [2:0]  MAX_SENDS_RESET = 3'd5;

	// Operation codes of a request.
	localparam logic [2:0] OP_LOOKUP = 3'd0;
	localparam logic [2:0] OP_INSERT = 3'd1;
	localparam logic [2:0] OP_QUEUE  = 3'd2;
	localparam logic [2:0] OP_REMOVE = 3'd3;
	localparam logic [2:0] OP_TICK   = 3'd4;
	localparam logic [2:0] OP_CLEAR  = 3'd5;

	// Result kinds.
	typedef enum logic [3:0] {
		K_HIT      = 4'd0,
		K_MISS     = 4'd1,
		K_INSERTED = 4'd2,
		K_QUEUED   = 4'd3,
		K_REMOVED  = 4'd4,
		K_SEND     = 4'd5,
		K_UNREACH  = 4'd6,
		K_TICK     = 4'd7,
		K_CLEARED  = 4'd8,
		K_FULL     = 4'd9
	} kind_t;

	// Source of the result payload.
	typedef enum logic [2:0] {
		SRC_IN,
		SRC_HIT,
		SRC_REQ,
		SRC_PKT,
		SRC_ZERO
	} src_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] ip_addr;
		logic [47:0] mac_addr;
		logic [15:0] packet_tag;
		logic [3:0]  iface_index;
	} in_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] out_ip;
		logic [47:0] out_mac;
		logic [15:0] out_tag;
		logic [3:0]  out_iface;
		logic        pending_found;
		logic        last;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic  cap;
		logic  cmp;
		logic  ins;
		logic  age_all;
		logic  drop_head;
		logic  clr;
		logic  q_add;
		logic  req_bump;
		logic  req_drop;
		logic  drop_walk;
		logic  w_clr;
		logic  w_inc;
		logic  p_clr;
		logic  p_inc;
		logic  emit;
		kind_t kind;
		src_t  src;
		logic  last;
		logic  pend;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [2:0] op;
		logic       ent_hit;
		logic       ent_full;
		logic       req_hit;
		logic       q_full;
		logic       head_exp;
		logic       walk_end;
		logic       walk_retire;
		logic       note_end;
	} sts_t;

endpackage

// ===== hdl/arpc_dp.sv =====
// Datapath of the ARP cache: entry table, request table, match logic and result register.
// Depends on arpc_pkg.
module arpc_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  arpc_pkg::cmd_t                      cmd,
	output arpc_pkg::sts_t                      sts,
	input  arpc_pkg::in_item_t                  request,
	input  logic                                cfg_we,
	input  logic [arpc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [15:0]                         cfg_data,
	output arpc_pkg::out_item_t                 result,
	output logic                                result_strobe
);

	localparam int ED = arpc_pkg::ENTRY_DEPTH;
	localparam int RD = arpc_pkg::REQ_DEPTH;
	localparam int PD = arpc_pkg::PENDING_DEPTH;
	localparam int EIW = arpc_pkg::EIDX_W;
	localparam int ECW = arpc_pkg::ECNT_W;
	localparam int RIW = arpc_pkg::RIDX_W;
	localparam int RCW = arpc_pkg::RCNT_W;
	localparam int PIW = arpc_pkg::PIDX_W;
	localparam int PCW = arpc_pkg::PCNT_W;

	arpc_pkg::in_item_t  in_q;
	logic [31:0]         ent_ip_q  [ED];
	logic [47:0]         ent_mac_q [ED];
	logic [15:0]         ent_age_q [ED];
	logic [ECW-1:0]      ecnt_q;
	logic [31:0]         req_ip_q   [RD];
	logic [2:0]          req_sent_q [RD];
	logic [PCW-1:0]      req_pcnt_q [RD];
	logic [15:0]         pkt_tag_q   [RD][PD];
	logic [3:0]          pkt_iface_q [RD][PD];
	logic [RCW-1:0]      rcnt_q;
	logic [ED-1:0]       ent_match_q;
	logic [RD-1:0]       req_match_q;
	logic [RCW-1:0]      w_q;
	logic [PCW-1:0]      p_q;
	logic [15:0]         timeout_q;
	logic [2:0]          max_sends_q;
	arpc_pkg::out_item_t res_q;
	logic                strobe_q;

	logic [EIW-1:0]      ent_hidx;
	logic [RIW-1:0]      req_hidx;
	logic                req_hit;
	logic [RIW-1:0]      w_idx;
	logic [PIW-1:0]      p_idx;
	logic [RIW-1:0]      drop_pos;
	logic [RIW-1:0]      add_row;
	logic [PCW-1:0]      add_slot;
	arpc_pkg::out_item_t res_d;

	// First matching entry and request; the lowest index wins.
	always_comb begin
		ent_hidx = '0;
		for (int i = ED - 1; i >= 0; i--) begin
			if (ent_match_q[i]) begin
				ent_hidx = EIW'(i);
			end
		end
		req_hidx = '0;
		for (int i = RD - 1; i >= 0; i--) begin
			if (req_match_q[i]) begin
				req_hidx = RIW'(i);
			end
		end
	end

	assign req_hit  = |req_match_q;
	assign w_idx    = w_q[RIW-1:0];
	assign p_idx    = p_q[PIW-1:0];
	assign drop_pos = cmd.drop_walk ? w_idx : req_hidx;
	assign add_row  = req_hit ? req_hidx : rcnt_q[RIW-1:0];
	assign add_slot = req_hit ? req_pcnt_q[req_hidx] : '0;

	// Status toward the controller.
	always_comb begin
		sts.op          = in_q.op;
		sts.ent_hit     = |ent_match_q;
		sts.ent_full    = (ecnt_q == ECW'(ED));
		sts.req_hit     = req_hit;
		sts.q_full      = req_hit ? (req_pcnt_q[req_hidx] == PCW'(PD))
		                          : (rcnt_q == RCW'(RD));
		sts.head_exp    = (ecnt_q != '0) && (ent_age_q[0] > timeout_q);
		sts.walk_end    = (w_q == rcnt_q);
		sts.walk_retire = (req_sent_q[w_idx] >= max_sends_q);
		sts.note_end    = (p_q == req_pcnt_q[w_idx]);
	end

	// Result payload selection.
	always_comb begin
		res_d               = '0;
		res_d.kind          = cmd.kind;
		res_d.last          = cmd.last;
		res_d.pending_found = cmd.pend & req_hit;
		unique case (cmd.src)
			arpc_pkg::SRC_IN: begin
				res_d.out_ip = in_q.ip_addr;
			end
			arpc_pkg::SRC_HIT: begin
				res_d.out_ip  = in_q.ip_addr;
				res_d.out_mac = ent_mac_q[ent_hidx];
			end
			arpc_pkg::SRC_REQ: begin
				res_d.out_ip = req_ip_q[w_idx];
			end
			arpc_pkg::SRC_PKT: begin
				res_d.out_ip    = req_ip_q[w_idx];
				res_d.out_tag   = pkt_tag_q[w_idx][p_idx];
				res_d.out_iface = pkt_iface_q[w_idx][p_idx];
			end
			default: begin
				res_d.out_ip = '0;
			end
		endcase
	end

	// Counters, pointers, configuration and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ecnt_q      <= '0;
			rcnt_q      <= '0;
			w_q         <= '0;
			p_q         <= '0;
			timeout_q   <= arpc_pkg::TIMEOUT_RESET;
			max_sends_q <= arpc_pkg::MAX_SENDS_RESET;
			strobe_q    <= 1'b0;
		end else begin
			if (cmd.clr) begin
				ecnt_q <= '0;
			end else if (cmd.ins) begin
				ecnt_q <= ecnt_q + 1'b1;
			end else if (cmd.drop_head) begin
				ecnt_q <= ecnt_q - 1'b1;
			end
			if (cmd.clr) begin
				rcnt_q <= '0;
			end else if (cmd.q_add && !req_hit) begin
				rcnt_q <= rcnt_q + 1'b1;
			end else if (cmd.req_drop) begin
				rcnt_q <= rcnt_q - 1'b1;
			end
			if (cmd.w_clr) begin
				w_q <= '0;
			end else if (cmd.w_inc) begin
				w_q <= w_q + 1'b1;
			end
			if (cmd.p_clr) begin
				p_q <= '0;
			end else if (cmd.p_inc) begin
				p_q <= p_q + 1'b1;
			end
			if (cfg_we) begin
				if (cfg_index == arpc_pkg::CFG_TIMEOUT) begin
					timeout_q <= cfg_data;
				end else if (cfg_index == arpc_pkg::CFG_MAX_SENDS) begin
					max_sends_q <= cfg_data[2:0];
				end
			end
			strobe_q <= cmd.emit;
		end
	end

	// Table contents, match vectors and the result payload.
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			in_q <= request;
		end
		if (cmd.cmp) begin
			for (int i = 0; i < ED; i++) begin
				ent_match_q[i] <= (ECW'(i) < ecnt_q) && (ent_ip_q[i] == in_q.ip_addr);
			end
			for (int i = 0; i < RD; i++) begin
				req_match_q[i] <= (RCW'(i) < rcnt_q) && (req_ip_q[i] == in_q.ip_addr);
			end
		end
		// Entry table: append, age, or drop the oldest entry at the head.
		if (cmd.ins) begin
			ent_ip_q[ecnt_q[EIW-1:0]]  <= in_q.ip_addr;
			ent_mac_q[ecnt_q[EIW-1:0]] <= in_q.mac_addr;
			ent_age_q[ecnt_q[EIW-1:0]] <= '0;
		end else if (cmd.age_all) begin
			for (int i = 0; i < ED; i++) begin
				if (ent_age_q[i] != '1) begin
					ent_age_q[i] <= ent_age_q[i] + 1'b1;
				end
			end
		end else if (cmd.drop_head) begin
			for (int i = 0; i + 1 < ED; i++) begin
				ent_ip_q[i]  <= ent_ip_q[i + 1];
				ent_mac_q[i] <= ent_mac_q[i + 1];
				ent_age_q[i] <= ent_age_q[i + 1];
			end
		end
		// Request table: add a packet, count a send, or close the gap of a dropped row.
		if (cmd.q_add) begin
			if (!req_hit) begin
				req_ip_q[add_row]   <= in_q.ip_addr;
				req_sent_q[add_row] <= '0;
			end
			pkt_tag_q[add_row][add_slot[PIW-1:0]]   <= in_q.packet_tag;
			pkt_iface_q[add_row][add_slot[PIW-1:0]] <= in_q.iface_index;
			req_pcnt_q[add_row] <= add_slot + 1'b1;
		end else if (cmd.req_bump) begin
			req_sent_q[w_idx] <= req_sent_q[w_idx] + 1'b1;
		end else if (cmd.req_drop) begin
			for (int j = 0; j + 1 < RD; j++) begin
				if (RIW'(j) >= drop_pos) begin
					req_ip_q[j]    <= req_ip_q[j + 1];
					req_sent_q[j]  <= req_sent_q[j + 1];
					req_pcnt_q[j]  <= req_pcnt_q[j + 1];
					pkt_tag_q[j]   <= pkt_tag_q[j + 1];
					pkt_iface_q[j] <= pkt_iface_q[j + 1];
				end
			end
		end
		if (cmd.emit) begin
			res_q <= res_d;
		end
	end

	assign result        = res_q;
	assign result_strobe = strobe_q;

`ifndef ASSERT_OFF
	// Table fill counts never pass the table sizes.
	a_ecnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		ecnt_q <= ECW'(ED)) else $error("entry count out of range");
	a_rcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		rcnt_q <= RCW'(RD)) else $error("request count out of range");
	// Every emit command puts a result on the ports in the next cycle.
	a_emit_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> strobe_q) else $error("emitted result not strobed");
`endif

endmodule

// ===== hdl/arpc_ctrl.sv =====
// Controller of the ARP cache: sequences lookup, insert, queue, remove, clear and tick.
// Depends on arpc_pkg.
module arpc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  arpc_pkg::sts_t sts,
	output arpc_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP,
		S_EXEC,
		S_EXPIRE,
		S_WALK,
		S_NOTE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.cap = 1'b1;
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				cmd.cmp = 1'b1;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d  = S_IDLE;
				cmd.last = 1'b1;
				cmd.src  = arpc_pkg::SRC_IN;
				unique case (sts.op)
					arpc_pkg::OP_LOOKUP: begin
						cmd.emit = 1'b1;
						cmd.kind = sts.ent_hit ? arpc_pkg::K_HIT : arpc_pkg::K_MISS;
						cmd.src  = sts.ent_hit ? arpc_pkg::SRC_HIT : arpc_pkg::SRC_IN;
					end
					arpc_pkg::OP_INSERT: begin
						cmd.emit = 1'b1;
						if (sts.ent_full) begin
							cmd.kind = arpc_pkg::K_FULL;
						end else begin
							cmd.ins  = 1'b1;
							cmd.pend = 1'b1;
							cmd.kind = arpc_pkg::K_INSERTED;
						end
					end
					arpc_pkg::OP_QUEUE: begin
						cmd.emit = 1'b1;
						if (sts.q_full) begin
							cmd.kind = arpc_pkg::K_FULL;
						end else begin
							cmd.q_add = 1'b1;
							cmd.kind  = arpc_pkg::K_QUEUED;
						end
					end
					arpc_pkg::OP_REMOVE: begin
						cmd.emit     = 1'b1;
						cmd.req_drop = sts.req_hit;
						cmd.kind     = arpc_pkg::K_REMOVED;
					end
					arpc_pkg::OP_TICK: begin
						cmd.last    = 1'b0;
						cmd.age_all = 1'b1;
						cmd.w_clr   = 1'b1;
						state_d     = S_EXPIRE;
					end
					arpc_pkg::OP_CLEAR: begin
						cmd.emit = 1'b1;
						cmd.clr  = 1'b1;
						cmd.kind = arpc_pkg::K_CLEARED;
						cmd.src  = arpc_pkg::SRC_ZERO;
					end
					default: begin
						cmd.last = 1'b0;
					end
				endcase
			end
			// Expired entries sit at the head, oldest first: drop one per cycle.
			S_EXPIRE: begin
				if (sts.head_exp) begin
					cmd.drop_head = 1'b1;
				end else begin
					state_d = S_WALK;
				end
			end
			// Visit each request: resend it or retire it.
			S_WALK: begin
				if (sts.walk_end) begin
					cmd.emit = 1'b1;
					cmd.kind = arpc_pkg::K_TICK;
					cmd.src  = arpc_pkg::SRC_ZERO;
					cmd.last = 1'b1;
					state_d  = S_IDLE;
				end else if (sts.walk_retire) begin
					cmd.p_clr = 1'b1;
					state_d   = S_NOTE;
				end else begin
					cmd.req_bump = 1'b1;
					cmd.emit     = 1'b1;
					cmd.kind     = arpc_pkg::K_SEND;
					cmd.src      = arpc_pkg::SRC_REQ;
					cmd.w_inc    = 1'b1;
				end
			end
			// One unreachable notice per queued packet, then free the request.
			S_NOTE: begin
				if (sts.note_end) begin
					cmd.req_drop  = 1'b1;
					cmd.drop_walk = 1'b1;
					state_d       = S_WALK;
				end else begin
					cmd.emit  = 1'b1;
					cmd.kind  = arpc_pkg::K_UNREACH;
					cmd.src   = arpc_pkg::SRC_PKT;
					cmd.p_inc = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and the busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
		end
	end

	assign busy = busy_q;

`ifndef ASSERT_OFF
	// Nothing is emitted while the controller is idle.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !cmd.emit) else $error("result emitted while idle");
`endif

endmodule

// ===== hdl/arp_cache_with_request_retry.sv =====
// Top level of the ARP cache with entry ageing and request retry.
// Depends on arpc_pkg, arpc_ctrl and arpc_dp.
//
// Channel   Direction  Handshake            Payload
// request   in         start & !busy        request (in_item_t)
// result    out        result_strobe        result (out_item_t), no back-pressure
// config    in         cfg_valid&cfg_ready  cfg_index, cfg_data
//
// Lookup, insert, queue, remove and clear give their result after the capture, compare
// and execute states; busy drops as it is strobed, so the next request can be taken then.
// A tick holds busy while it ages every entry, drops expired entries from the head and
// walks the request table in order, resending each request or retiring it with notices.
// Reset empties both tables and restores the register defaults; no clearing pass.
// The result side cannot stall; config is taken whenever busy is low.
module arp_cache_with_request_retry (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  arpc_pkg::in_item_t              request,
	output arpc_pkg::out_item_t             result,
	output logic                            result_strobe,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [arpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [15:0]                     cfg_data
);

	arpc_pkg::cmd_t cmd;
	arpc_pkg::sts_t sts;
	logic           cfg_we;

	// Configuration is taken between requests only.
	assign cfg_ready = ~busy;
	assign cfg_we    = cfg_valid & cfg_ready;

	arpc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	arpc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.request       (request),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.result        (result),
		.result_strobe (result_strobe)
	);

endmodule
